/* rtl/core/vsr_pkg.sv */
package vsr_pkg;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 24;
  localparam int POS_W  = 6;
  localparam int BOX_W  = 7;
  localparam int REG_W  = 7;
  localparam int CNT_W  = 19;
  localparam int SQ_W   = 14;
  localparam int DIST_W = 16;
  localparam int R2_W   = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic FUNC_SPHERE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  localparam logic [REG_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic setup;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic zero_radius;
    logic walk_last;
  } sts_t;

endpackage

/* rtl/core/vsr_ctrl.sv */
module vsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  vsr_pkg::sts_t sts,
  output vsr_pkg::cmd_t cmd
);
  import vsr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.is_read || sts.zero_radius) state_nxt = ST_DONE;
        else state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/core/vsr_dp.sv */
module vsr_dp #(
  parameter int MAX_DIM = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_func,
  input  logic [vsr_pkg::POS_W-1:0]  in_pos_x,
  input  logic [vsr_pkg::POS_W-1:0]  in_pos_y,
  input  logic [vsr_pkg::POS_W-1:0]  in_pos_z,
  input  logic [vsr_pkg::POS_W-1:0]  in_radius,
  input  logic [vsr_pkg::REG_W-1:0]  grid_width,
  input  logic [vsr_pkg::REG_W-1:0]  grid_height,
  input  logic [vsr_pkg::REG_W-1:0]  grid_depth,
  input  vsr_pkg::cmd_t              cmd,
  output vsr_pkg::sts_t              sts,
  output logic                       occupied,
  output logic [vsr_pkg::CNT_W-1:0]  cells_marked
);
  import vsr_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int RA    = $clog2(DEPTH);
  localparam logic [RA-1:0] CLR_LAST = RA'(DEPTH - 1);

  function automatic logic [REG_W-1:0] ext_of(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] e;
    if (v == '0) e = REG_W'(1);
    else if (32'(v) > MAX_DIM) e = REG_W'(MAX_DIM);
    else e = v;
    return e;
  endfunction

  function automatic logic [BOX_W-1:0] box_lo(input logic [POS_W-1:0] c,
                                              input logic [POS_W-1:0] r,
                                              input logic [BOX_W-1:0] lim);
    logic [BOX_W:0]   d;
    logic [BOX_W-1:0] lo;
    d  = (BOX_W+1)'(c) - (BOX_W+1)'(r);
    lo = d[BOX_W] ? '0 : d[BOX_W-1:0];
    return (lo > lim) ? lim : lo;
  endfunction

  function automatic logic [BOX_W-1:0] box_hi(input logic [POS_W-1:0] c,
                                              input logic [POS_W-1:0] r,
                                              input logic [BOX_W-1:0] lim);
    logic [BOX_W-1:0] hi;
    hi = BOX_W'(c) + BOX_W'(r);
    return (hi > lim) ? lim : hi;
  endfunction

  function automatic logic [SQ_W-1:0] sq_dist(input logic [BOX_W-1:0] p,
                                              input logic [POS_W-1:0] c);
    logic [BOX_W-1:0] a;
    a = (p >= BOX_W'(c)) ? (p - BOX_W'(c)) : (BOX_W'(c) - p);
    return SQ_W'(a) * SQ_W'(a);
  endfunction

  function automatic logic [RA-1:0] row_of(input logic [BOX_W-1:0] y,
                                           input logic [BOX_W-1:0] z);
    return RA'(RA'(z) * RA'(MAX_DIM) + RA'(y));
  endfunction

  logic [MAX_DIM-1:0] mem [DEPTH];
  logic [MAX_DIM-1:0] rd_data_r;

  logic             func_r;
  logic [POS_W-1:0] cx_r, cy_r, cz_r, r_r;
  logic [R2_W-1:0]  r2_r;
  logic [BOX_W-1:0] x0_r, x1_r, y0_r, y1_r, z1_r;
  logic [BOX_W-1:0] x_r, y_r, z_r;
  logic [MAX_DIM-1:0] mask_r;
  logic [CNT_W-1:0] count_r;
  logic [RA-1:0]    clr_cnt_r;
  logic             occ_r;
  logic [CNT_W-1:0] marked_r;

  logic [REG_W-1:0] ew, eh, ed;
  logic [BOX_W-1:0] wm1, hm1, dm1;
  logic [DIST_W-1:0] dsq;
  logic             hit, x_end, y_end, z_end, in_grid;
  logic [MAX_DIM-1:0] mask_cur;
  logic             wr_en, wr_bit;
  logic [RA-1:0]    wr_addr;
  logic [MAX_DIM-1:0] wr_mask;

  assign ew  = ext_of(grid_width);
  assign eh  = ext_of(grid_height);
  assign ed  = ext_of(grid_depth);
  assign wm1 = ew - REG_W'(1);
  assign hm1 = eh - REG_W'(1);
  assign dm1 = ed - REG_W'(1);

  assign dsq = DIST_W'(sq_dist(x_r, cx_r)) + DIST_W'(sq_dist(y_r, cy_r))
             + DIST_W'(sq_dist(z_r, cz_r));
  assign hit   = dsq <= DIST_W'(r2_r);
  assign x_end = x_r == x1_r;
  assign y_end = y_r == y1_r;
  assign z_end = z_r == z1_r;
  assign mask_cur = mask_r | (hit ? (MAX_DIM'(1) << CW'(x_r)) : '0);

  assign in_grid = (BOX_W'(cx_r) < ew) && (BOX_W'(cy_r) < eh) && (BOX_W'(cz_r) < ed);

  always_comb begin
    wr_en   = cmd.clr_step || (cmd.walk && x_end);
    wr_bit  = !cmd.clr_step;
    wr_addr = cmd.clr_step ? clr_cnt_r : row_of(y_r, z_r);
    wr_mask = cmd.clr_step ? '1 : mask_cur;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        if (wr_mask[i]) mem[wr_addr][i] <= wr_bit;
      end
    end
    if (cmd.setup) rd_data_r <= mem[row_of(BOX_W'(cy_r), BOX_W'(cz_r))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + RA'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      cx_r    <= in_pos_x;
      cy_r    <= in_pos_y;
      cz_r    <= in_pos_z;
      r_r     <= in_radius;
      count_r <= '0;
    end
    if (cmd.setup) begin
      r2_r   <= R2_W'(r_r) * R2_W'(r_r);
      x0_r   <= box_lo(cx_r, r_r, wm1);
      x1_r   <= box_hi(cx_r, r_r, wm1);
      y0_r   <= box_lo(cy_r, r_r, hm1);
      y1_r   <= box_hi(cy_r, r_r, hm1);
      z1_r   <= box_hi(cz_r, r_r, dm1);
      x_r    <= box_lo(cx_r, r_r, wm1);
      y_r    <= box_lo(cy_r, r_r, hm1);
      z_r    <= box_lo(cz_r, r_r, dm1);
      mask_r <= '0;
    end
    if (cmd.walk) begin
      if (hit && count_r != CNT_MAX) count_r <= count_r + CNT_W'(1);
      if (x_end) begin
        x_r    <= x0_r;
        mask_r <= '0;
        if (y_end) begin
          y_r <= y0_r;
          z_r <= z_r + BOX_W'(1);
        end else begin
          y_r <= y_r + BOX_W'(1);
        end
      end else begin
        x_r    <= x_r + BOX_W'(1);
        mask_r <= mask_cur;
      end
    end
    if (cmd.finish) begin
      occ_r    <= (func_r == FUNC_READ) && in_grid && rd_data_r[CW'(cx_r)];
      marked_r <= count_r;
    end
  end

  always_comb begin
    sts.clr_last    = clr_cnt_r == CLR_LAST;
    sts.is_read     = func_r == FUNC_READ;
    sts.zero_radius = r_r == '0;
    sts.walk_last   = x_end && y_end && z_end;
  end

  assign occupied     = occ_r;
  assign cells_marked = marked_r;

endmodule

/* rtl/core/voxel_sphere_rasterizer.sv */
// Sphere command: the walk visits the cells of the clamped bounding box one cell per
// cycle (a zero radius skips the walk).
// Read command: one occupancy memory row read.
// One command in flight: the next input beat is taken only after the previous result has
// entered the output register, which must first drain. After reset a clearing pass writes
// MAX_DIM*MAX_DIM rows with in_tready low; the grid registers reset to 64.
module voxel_sphere_rasterizer #(
  parameter int MAX_DIM = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [vsr_pkg::IN_W-1:0]  in_tdata,   // pos_x[5:0], pos_y[11:6], pos_z[17:12], radius[23:18]
  input  logic                      in_tuser,   // func
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [vsr_pkg::OUT_W-1:0] out_tdata,  // occupied[0], cells_marked[19:1], zero[23:20]
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [3:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import vsr_pkg::*;

  logic [REG_W-1:0] grid_width_r, grid_height_r, grid_depth_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  cmd_t             cmd;
  sts_t             sts;
  logic             occupied;
  logic [CNT_W-1:0] cells_marked;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
      grid_depth_r  <= GRID_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  grid_width_r  <= cfg_pwdata[REG_W-1:0];
        REG_HEIGHT: grid_height_r <= cfg_pwdata[REG_W-1:0];
        REG_DEPTH:  grid_depth_r  <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  cfg_prdata = 32'(grid_width_r);
      REG_HEIGHT: cfg_prdata = 32'(grid_height_r);
      REG_DEPTH:  cfg_prdata = 32'(grid_depth_r);
      default:    cfg_prdata = '0;
    endcase
  end

  vsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  vsr_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_tuser),
    .in_pos_x     (in_tdata[5:0]),
    .in_pos_y     (in_tdata[11:6]),
    .in_pos_z     (in_tdata[17:12]),
    .in_radius    (in_tdata[23:18]),
    .grid_width   (grid_width_r),
    .grid_height  (grid_height_r),
    .grid_depth   (grid_depth_r),
    .cmd          (cmd),
    .sts          (sts),
    .occupied     (occupied),
    .cells_marked (cells_marked)
  );

  assign out_tdata = {4'b0, cells_marked, occupied};

endmodule

/* tb/voxel_sphere_rasterizer_tb.sv */
module voxel_sphere_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsr_pkg::*;

  localparam int DIM = 64;
  localparam int STALL_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 12;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [POS_W-1:0] r;
  } voxel_cmd_t;

  typedef struct packed {
    logic             occupied;
    logic [CNT_W-1:0] cells_marked;
  } voxel_res_t;

  typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    voxel_cmd_t       cmd;
    bit               typed;
    voxel_res_t       want;
    logic [1:0]       reg_idx;
    logic [REG_W-1:0] reg_val;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // pos_x[5:0], pos_y[11:6], pos_z[17:12], radius[23:18]
  logic        in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // occupied[0], cells_marked[19:1], zero[23:20]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit               occ_map [0:DIM*DIM*DIM-1];
  logic [REG_W-1:0] grid_reg [0:2];
  voxel_res_t       results_due [$];
  directed_row_t    directed_rows [$];
  voxel_cmd_t       last_sphere;
  int               mismatch_count;
  bit               tx_idle;
  bit               rx_stall;
  int               idle_pct;
  bit               hold_req;

  voxel_sphere_rasterizer #(.MAX_DIM(DIM)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int axis_span(logic [REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic int clamp_axis(int v, int ext);
    if (v < 0) return 0;
    if (v > ext - 1) return ext - 1;
    return v;
  endfunction

  // Applies one command to the shadow volume and returns its result beat.
  function automatic voxel_res_t voxel_outcome(voxel_cmd_t c);
    voxel_res_t res;
    int w, h, d, cx, cy, cz, r, r2;
    int x0, x1, y0, y1, z0, z1, cnt;
    w = axis_span(grid_reg[REG_WIDTH]);
    h = axis_span(grid_reg[REG_HEIGHT]);
    d = axis_span(grid_reg[REG_DEPTH]);
    cx = c.x;
    cy = c.y;
    cz = c.z;
    r = c.r;
    res = '0;
    if (c.func == FUNC_READ) begin
      if (cx < w && cy < h && cz < d)
        res.occupied = occ_map[(cz * DIM + cy) * DIM + cx];
      return res;
    end
    if (r == 0) return res;
    x0 = clamp_axis(cx - r, w);
    x1 = clamp_axis(cx + r, w);
    y0 = clamp_axis(cy - r, h);
    y1 = clamp_axis(cy + r, h);
    z0 = clamp_axis(cz - r, d);
    z1 = clamp_axis(cz + r, d);
    r2 = r * r;
    cnt = 0;
    for (int z = z0; z <= z1; z++) begin
      for (int y = y0; y <= y1; y++) begin
        for (int x = x0; x <= x1; x++) begin
          if ((x - cx) * (x - cx) + (y - cy) * (y - cy) + (z - cz) * (z - cz) <= r2) begin
            occ_map[(z * DIM + y) * DIM + x] = 1'b1;
            if (cnt < CNT_MAX) cnt++;
          end
        end
      end
    end
    res.cells_marked = CNT_W'(cnt);
    return res;
  endfunction

  function automatic void add_cmd(logic func, int x, int y, int z, int r,
                                  bit typed = 1'b0, logic occ = 1'b0, int cnt = 0);
    directed_row_t row;
    row.kind = ROW_CMD;
    row.cmd.func = func;
    row.cmd.x = POS_W'(x);
    row.cmd.y = POS_W'(y);
    row.cmd.z = POS_W'(z);
    row.cmd.r = POS_W'(r);
    row.typed = typed;
    row.want.occupied = occ;
    row.want.cells_marked = CNT_W'(cnt);
    row.reg_idx = '0;
    row.reg_val = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [1:0] idx, int val);
    directed_row_t row;
    row.kind = ROW_REG;
    row.cmd = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.reg_idx = idx;
    row.reg_val = REG_W'(val);
    directed_rows.push_back(row);
  endfunction

  function automatic logic [POS_W-1:0] near_axis(logic [POS_W-1:0] base,
                                                 logic [POS_W-1:0] rad);
    int v, rr, off;
    v = base;
    rr = rad;
    off = $urandom_range(2 * rr + 2);
    v = v + off - rr - 1;
    return POS_W'(clamp_axis(v, DIM));
  endfunction

  function automatic voxel_cmd_t random_cmd(bit narrow);
    voxel_cmd_t c;
    int pick;
    c.func = ($urandom_range(99) < 45) ? FUNC_SPHERE : FUNC_READ;
    c.x = POS_W'($urandom_range(63));
    c.y = POS_W'($urandom_range(63));
    c.z = POS_W'($urandom_range(63));
    c.r = POS_W'($urandom_range(63));
    if (c.func == FUNC_SPHERE) begin
      if (narrow) begin
        if ($urandom_range(3) != 0) begin
          c.x = POS_W'($urandom_range(axis_span(grid_reg[REG_WIDTH]) + 1));
          c.y = POS_W'($urandom_range(axis_span(grid_reg[REG_HEIGHT]) + 1));
          c.z = POS_W'($urandom_range(axis_span(grid_reg[REG_DEPTH]) + 1));
        end
      end else begin
        // keep the walked box modest on a wide grid
        pick = $urandom_range(99);
        if (pick < 75) c.r = POS_W'($urandom_range(6));
        else if (pick < 95) c.r = POS_W'($urandom_range(12, 7));
        else c.r = POS_W'($urandom_range(20, 13));
      end
      last_sphere = c;
    end else if ($urandom_range(99) < 60) begin
      c.x = near_axis(last_sphere.x, last_sphere.r);
      c.y = near_axis(last_sphere.y, last_sphere.r);
      c.z = near_axis(last_sphere.z, last_sphere.r);
    end
    return c;
  endfunction

  task automatic send_cmd(input voxel_cmd_t c, input bit typed, input voxel_res_t want);
    voxel_res_t got;
    while (tx_idle && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.func;
    in_tdata <= {c.r, c.z, c.y, c.x};
    do @(posedge clk); while (!in_tready);
    got = voxel_outcome(c);
    results_due.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
    logic [24:0] junk;
    junk = 25'($urandom);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {junk, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    if (idx <= REG_DEPTH) begin
      grid_reg[idx] = val;
      cfg_pwrite <= 1'b0;
      cfg_penable <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      if (cfg_prdata !== 32'(val))
        flag_mismatch($sformatf("reg %0d read %h, wrote %h", idx, cfg_prdata, val));
      @(negedge clk);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  initial begin : rx_side
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stall && $urandom_range(99) < idle_pct) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    voxel_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat %h", out_tdata));
      end else begin
        want = results_due.pop_front();
        if (out_tdata[0] !== want.occupied)
          flag_mismatch($sformatf("occupied %b, want %b", out_tdata[0], want.occupied));
        if (out_tdata[19:1] !== want.cells_marked)
          flag_mismatch($sformatf("cells_marked %0d, want %0d",
                                  out_tdata[19:1], want.cells_marked));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    voxel_cmd_t c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatch_count = 0;
    tx_idle = 1'b0;
    rx_stall = 1'b0;
    idle_pct = 61;
    hold_req = 1'b0;
    last_sphere = '0;
    for (int i = 0; i < 3; i++) grid_reg[i] = GRID_RESET;

    add_cmd(FUNC_READ,    0,  0,  0, 0, 1'b1, 1'b0, 0);
    add_cmd(FUNC_READ,   63, 63, 63, 0, 1'b1, 1'b0, 0);
    add_cmd(FUNC_SPHERE, 10, 10, 10, 0, 1'b1, 1'b0, 0);
    add_cmd(FUNC_READ,   10, 10, 10, 0, 1'b1, 1'b0, 0);
    add_cmd(FUNC_SPHERE, 10, 10, 10, 1, 1'b1, 1'b0, 7);
    add_cmd(FUNC_READ,   11, 10, 10, 0, 1'b1, 1'b1, 0);
    add_cmd(FUNC_READ,   11, 11, 10, 0, 1'b1, 1'b0, 0);
    add_cmd(FUNC_SPHERE,  0,  0,  0, 1, 1'b1, 1'b0, 4);
    add_cmd(FUNC_SPHERE, 63, 63, 63, 2);
    add_cmd(FUNC_READ,   63, 63, 63, 0, 1'b1, 1'b1, 0);
    add_cmd(FUNC_SPHERE, 40, 20, 50, 5);
    add_cmd(FUNC_SPHERE, 40, 20, 50, 5);
    add_cmd(FUNC_SPHERE,  0, 63,  0, 3);
    add_cmd(FUNC_READ,   41, 22, 47, 0);
    // single-cell grid: register zero counts as one
    add_reg(REG_WIDTH, 0);
    add_reg(REG_HEIGHT, 0);
    add_reg(REG_DEPTH, 0);
    add_cmd(FUNC_SPHERE,  5,  5,  5, 63, 1'b1, 1'b0, 1);
    add_cmd(FUNC_READ,    1,  0,  0, 0, 1'b1, 1'b0, 0);
    add_cmd(FUNC_READ,    0,  0,  0, 0, 1'b1, 1'b1, 0);
    // one row along x; oversized width saturates, spare index is ignored
    add_reg(REG_WIDTH, 127);
    add_reg(REG_HEIGHT, 1);
    add_reg(REG_DEPTH, 1);
    add_reg(REG_SPARE, 'h55);
    add_cmd(FUNC_SPHERE, 63,  0,  0, 63, 1'b1, 1'b0, 64);
    add_cmd(FUNC_READ,    5,  1,  0, 0, 1'b1, 1'b0, 0);
    add_reg(REG_WIDTH, 64);
    add_reg(REG_HEIGHT, 127);
    add_reg(REG_DEPTH, 65);
    add_cmd(FUNC_READ,    1,  0,  0, 0, 1'b1, 1'b1, 0);
    add_cmd(FUNC_READ,   33,  0,  0, 0, 1'b1, 1'b1, 0);
    add_cmd(FUNC_SPHERE, 63,  0, 63, 8);
    add_cmd(FUNC_READ,   30, 40,  2, 0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // idle modes: none, sender 61%, receiver 61%, both 15%
    for (int mode = 0; mode < 4; mode++) begin
      for (int narrow = 0; narrow < 2; narrow++) begin
        drain_results();
        tx_idle = (mode == 1 || mode == 3);
        rx_stall = (mode == 2 || mode == 3);
        idle_pct = (mode == 3) ? 15 : 61;
        for (int a = 0; a < 3; a++)
          write_reg(2'(a), REG_W'(narrow ? $urandom_range(12) : $urandom_range(127, 40)));
        if (mode == 0 && narrow == 0) hold_req = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          c = random_cmd(narrow[0]);
          send_cmd(c, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
